FILE: sv/kvj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvj_pkg
// shared types, sizes and codes for the key/value jar table
// ----------------------------------------------------------------------------
package kvj_pkg;

  localparam int SLOTS  = 64;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CAP_W  = 7;
  localparam int CMP_W  = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
  localparam int WORD_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // command codes
  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOJAR    = 2'd3;

  // register index, taken from paddr bit 2
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_JAR      = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  key_en;
    logic  val_en;
    addr_t addr;
    word_t key;
    word_t value;
  } wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_SHIFT,
    S_FIN
  } state_e;

endpackage : kvj_pkg
`default_nettype wire

FILE: sv/kvj_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvj_store
// key and value memories, one write port and one registered read port
// ----------------------------------------------------------------------------
module kvj_store (
  input  wire logic          clk_i,
  input  wire kvj_pkg::addr_t raddr_i,
  output      kvj_pkg::word_t rkey_o,
  output      kvj_pkg::word_t rval_o,
  input  wire kvj_pkg::wr_t   wr_i
);
  import kvj_pkg::*;

  word_t key_mem [SLOTS];
  word_t val_mem [SLOTS];
  word_t rkey_q;
  word_t rval_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.key_en) begin
      key_mem[wr_i.addr] <= wr_i.key;
    end
    if (wr_i.val_en) begin
      val_mem[wr_i.addr] <= wr_i.value;
    end
    rkey_q <= key_mem[raddr_i];
    rval_q <= val_mem[raddr_i];
  end

  assign rkey_o = rkey_q;
  assign rval_o = rval_q;

endmodule : kvj_store
`default_nettype wire

FILE: sv/key_value_jar_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_jar_table_core
// ordered table of 32-bit key/value pairs with get, set and remove commands
// ----------------------------------------------------------------------------
// a hit at slot p answers once the scan reaches slot p, a miss once the scan
//   has passed every used entry; remove trades the rest of the scan for
//   moving each later entry down one slot
// one command at a time; in_stall_o holds until the result is registered
// reset: used count, capacity (64), installed flag (1) and handshake state
//   clear at once; the memories need no clearing pass
module key_value_jar_table_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // command channel
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [1:0]                command_i,
  input  wire logic [kvj_pkg::WORD_W-1:0] key_i,
  input  wire logic [kvj_pkg::WORD_W-1:0] write_value_i,
  // result channel
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [1:0]                status_o,
  output      logic [kvj_pkg::WORD_W-1:0] read_value_o,
  // register port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kvj_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready
);
  import kvj_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_q;
  logic             jar_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      jar_q <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CAPACITY: cap_q <= pwdata[CAP_W-1:0];
        REG_JAR:      jar_q <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, cap_q};
      REG_JAR:      prdata = {31'd0, jar_q};
      default:      prdata = '0;
    endcase
  end

  // usable capacity saturates at the physical slot count
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_sat;
  logic             append_ok;

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  state_e      state_q, state_d;
  cnt_t        used_q, used_d;
  addr_t       idx_q, idx_d;
  logic [1:0]  cmd_q, cmd_d;
  word_t       key_q, key_d;
  word_t       wval_q, wval_d;
  logic [1:0]  res_stat_q, res_stat_d;
  word_t       res_val_q, res_val_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_stat_q, out_stat_d;
  word_t       out_val_q, out_val_d;

  // memory access
  addr_t       raddr;
  word_t       rkey;
  word_t       rval;
  wr_t         wr;

  logic        in_acc;
  logic        out_free;
  logic        hit;
  logic        last_scan;
  logic        more_shift;

  assign cap_ext   = CMP_W'(cap_q);
  assign cap_sat   = (cap_ext > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : cap_ext;
  // used+1 < cap also keeps one slot free and used below SLOTS
  assign append_ok = (CMP_W'(used_q) + CMP_W'(1)) < cap_sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // read data lines up with idx_q while scanning
  assign hit        = (rkey == key_q);
  assign last_scan  = ((CNT_W'(idx_q) + CNT_W'(1)) == used_q);
  // in the shift loop the read data is entry idx+1, written down to idx
  assign more_shift = ((CNT_W'(idx_q) + CNT_W'(2)) < used_q);

  kvj_store u_store (
    .clk_i   (clk_i),
    .raddr_i (raddr),
    .rkey_o  (rkey),
    .rval_o  (rval),
    .wr_i    (wr)
  );

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    wval_d     = wval_q;
    res_stat_d = res_stat_q;
    res_val_d  = res_val_q;
    raddr      = idx_q;
    wr         = '0;
    wr.addr    = idx_q;
    wr.key     = rkey;
    wr.value   = rval;

    case (state_q)
      S_IDLE: begin
        raddr = '0;
        if (in_acc) begin
          cmd_d      = command_i;
          key_d      = key_i;
          wval_d     = write_value_i;
          res_val_d  = '0;
          res_stat_d = STAT_NOTFOUND;
          idx_d      = '0;
          if (!jar_q) begin
            res_stat_d = STAT_NOJAR;
            state_d    = S_FIN;
          end else if (command_i == CMD_NONE || key_i == '0) begin
            state_d = S_FIN;
          end else if (used_q == '0) begin
            state_d = S_MISS;
          end else begin
            // read of slot 0 is in flight
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_stat_d = STAT_OK;
          case (cmd_q)
            CMD_GET: begin
              res_val_d = rval;
              state_d   = S_FIN;
            end
            CMD_SET: begin
              wr.val_en = 1'b1;
              wr.value  = wval_q;
              state_d   = S_FIN;
            end
            CMD_REMOVE: begin
              if (last_scan) begin
                used_d  = used_q - CNT_W'(1);
                state_d = S_FIN;
              end else begin
                raddr   = idx_q + ADDR_W'(1);
                state_d = S_SHIFT;
              end
            end
            default: state_d = S_FIN;
          endcase
        end else if (last_scan) begin
          state_d = S_MISS;
        end else begin
          raddr = idx_q + ADDR_W'(1);
          idx_d = idx_q + ADDR_W'(1);
        end
      end

      S_MISS: begin
        // key absent: only set can append
        if (cmd_q == CMD_SET) begin
          if (append_ok) begin
            wr.key_en  = 1'b1;
            wr.val_en  = 1'b1;
            wr.addr    = used_q[ADDR_W-1:0];
            wr.key     = key_q;
            wr.value   = wval_q;
            used_d     = used_q + CNT_W'(1);
            res_stat_d = STAT_OK;
          end else begin
            res_stat_d = STAT_FULL;
          end
        end else begin
          res_stat_d = STAT_NOTFOUND;
        end
        state_d = S_FIN;
      end

      S_SHIFT: begin
        // close the gap one entry per cycle, read runs one slot ahead
        wr.key_en = 1'b1;
        wr.val_en = 1'b1;
        if (more_shift) begin
          raddr = ADDR_W'(CNT_W'(idx_q) + CNT_W'(2));
          idx_d = idx_q + ADDR_W'(1);
        end else begin
          used_d  = used_q - CNT_W'(1);
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // result beat leaves through the output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    if (state_q == S_FIN && out_free) begin
      out_valid_d = 1'b1;
      out_stat_d  = res_stat_q;
      out_val_d   = res_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    wval_q     <= wval_d;
    res_stat_q <= res_stat_d;
    res_val_q  <= res_val_d;
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_stat_q;
  assign read_value_o = out_val_q;

endmodule : key_value_jar_table_core
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the key/value jar table: a scoreboard keeps its own
// copy of the table, predicts the answer to each command beat and checks
// every result beat in order; both channels idle at random, and the register
// port walks capacity and the installed flag through their extremes
// ----------------------------------------------------------------------------
module testbench;
  import kvj_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int POOL         = 96;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [1:0] status;
    word_t      value;
  } answer_t;

  // keeps the table contents as the block should hold them and queues the
  // answer to every accepted command
  class jar_scoreboard;
    word_t   key_mem[SLOTS];
    word_t   value_mem[SLOTS];
    int      entries;
    int      capacity;
    bit      installed;
    answer_t expected_answers[$];
    int      errors;

    function new();
      entries   = 0;
      capacity  = int'(CAP_RESET);
      installed = 1'b1;
      errors    = 0;
    endfunction

    function void note_command(logic [1:0] cmd, word_t key, word_t wval);
      answer_t ans;
      int      hit;
      int      usable;
      int      i;
      ans.status = STAT_NOTFOUND;
      ans.value  = '0;
      usable     = (capacity > SLOTS) ? SLOTS : capacity;
      hit        = -1;
      if (!installed) begin
        ans.status = STAT_NOJAR;
      end else if (cmd != CMD_NONE && key != '0) begin
        for (i = 0; i < entries; i++) begin
          if (hit < 0 && key_mem[i] == key) hit = i;
        end
        if (cmd == CMD_GET) begin
          if (hit >= 0) begin
            ans.status = STAT_OK;
            ans.value  = value_mem[hit];
          end
        end else if (cmd == CMD_SET) begin
          if (hit >= 0) begin
            value_mem[hit] = wval;
            ans.status     = STAT_OK;
          end else if (usable >= 1 && entries < usable - 1) begin
            key_mem[entries]   = key;
            value_mem[entries] = wval;
            entries++;
            ans.status = STAT_OK;
          end else begin
            ans.status = STAT_FULL;
          end
        end else if (hit >= 0) begin
          // remove closes the gap so the order is kept
          for (i = hit; i + 1 < entries; i++) begin
            key_mem[i]   = key_mem[i + 1];
            value_mem[i] = value_mem[i + 1];
          end
          entries--;
          ans.status = STAT_OK;
        end
      end
      expected_answers.push_back(ans);
    endfunction

    function void check_result(logic [1:0] status, word_t value);
      answer_t ans;
      if (expected_answers.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result beat: status %0d read_value %h", status, value);
        return;
      end
      ans = expected_answers.pop_front();
      if (status !== ans.status || value !== ans.value) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: status exp %0d got %0d, read_value exp %h got %h",
                   ans.status, status, ans.value, value);
      end
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [1:0]  command_i     = CMD_GET;
  word_t       key_i         = '0;
  word_t       write_value_i = '0;
  logic        out_stall_i   = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr  = '0;
  logic [31:0] pwdata        = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  word_t       read_value_o;
  logic [31:0] prdata;
  logic        pready;

  jar_scoreboard sb = new();

  word_t key_pool[POOL];
  int    cycles       = 0;
  bit    hold_request = 1'b0;

  // idle pattern state: each side runs stretches of random gaps or stretches
  // of back-to-back beats, picked at random
  int    tx_left = 0;
  bit    tx_calm = 1'b0;
  int    rx_left = 0;
  bit    rx_calm = 1'b0;

  key_value_jar_table_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // watchdog, far above the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // number of idle cycles before the next beat on one side
  function automatic int draw_gap(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(10, 40);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // a small share of unknown commands, the rest weighted per phase
  function automatic logic [1:0] pick_cmd(int set_pct, int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return CMD_NONE;
    if (r < 5 + set_pct) return CMD_SET;
    if (r < 5 + set_pct + rem_pct) return CMD_REMOVE;
    return CMD_GET;
  endfunction

  // mostly keys from the pool so that hits, updates and removes happen
  function automatic word_t pick_key(int pool_used);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return $urandom;
    return key_pool[$urandom_range(0, pool_used - 1)];
  endfunction

  // offers one command beat and waits until the block takes it
  task automatic push_command(logic [1:0] cmd, word_t k, word_t v);
    int gap;
    gap = draw_gap(tx_left, tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    key_i         <= k;
    write_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, k, v);
  endtask

  // drop valid and wait for every outstanding answer
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk_i);
  endtask

  // register write while idle: setup cycle, access cycle, then mirror it
  task automatic set_register(logic idx, logic [31:0] data);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CAPACITY) sb.capacity = int'(data[CAP_W-1:0]);
    else sb.installed = data[0];
  endtask

  task automatic run_random(int count, int pool_used, int set_pct, int rem_pct);
    int n;
    for (n = 0; n < count; n++)
      push_command(pick_cmd(set_pct, rem_pct), pick_key(pool_used), $urandom);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int w;
    int n;
    wait (rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end
      w = draw_gap(rx_left, rx_calm);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(status_o, read_value_o);
    end
  end

  // command side and register sequence
  initial begin
    int i;
    for (i = 0; i < POOL; i++) begin
      do key_pool[i] = $urandom; while (key_pool[i] == '0);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes of key and value, update, order kept
    push_command(CMD_GET,    32'h0000_0001, 32'h0);
    push_command(CMD_REMOVE, 32'h0000_0001, 32'h0);
    push_command(CMD_SET,    32'h0000_0001, 32'hFFFF_FFFF);
    push_command(CMD_SET,    32'h8000_0000, 32'h0000_0000);
    push_command(CMD_SET,    32'hFFFF_FFFF, 32'hA5A5_5A5A);
    push_command(CMD_GET,    32'h0000_0001, 32'h0);
    push_command(CMD_GET,    32'h8000_0000, 32'h0);
    push_command(CMD_GET,    32'hFFFF_FFFF, 32'h0);
    push_command(CMD_SET,    32'h8000_0000, 32'h1234_5678);
    push_command(CMD_GET,    32'h8000_0000, 32'hFFFF_FFFF);
    // reserved key zero never hits
    push_command(CMD_GET,    32'h0, 32'h0);
    push_command(CMD_SET,    32'h0, 32'hFFFF_FFFF);
    push_command(CMD_REMOVE, 32'h0, 32'h0);
    // unknown command leaves the table alone
    push_command(CMD_NONE,   32'h0000_0001, 32'hFFFF_FFFF);
    push_command(CMD_NONE,   32'hFFFF_FFFF, 32'h0);
    // remove the first entry, the rest moves down
    push_command(CMD_REMOVE, 32'h0000_0001, 32'h0);
    push_command(CMD_GET,    32'h8000_0000, 32'h0);
    push_command(CMD_GET,    32'hFFFF_FFFF, 32'h0);
    push_command(CMD_GET,    32'h0000_0001, 32'h0);
    // remove the last entry
    push_command(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    push_command(CMD_GET,    32'h8000_0000, 32'h0);

    // tiny table, three entries fit
    set_register(REG_CAPACITY, 32'd4);
    run_random(60, 8, 40, 20);

    // capacity above the slot count saturates; fill the table to the top
    set_register(REG_CAPACITY, 32'd127);
    run_random(60, POOL, 65, 5);
    // result side holds off while commands keep coming
    hold_request = 1'b1;
    run_random(110, POOL, 55, 10);

    // capacity lowered below the contents: appends full, others still work
    set_register(REG_CAPACITY, 32'd5);
    run_random(50, POOL, 35, 35);

    // capacity zero and one: nothing can be appended
    set_register(REG_CAPACITY, 32'd0);
    run_random(30, 16, 40, 20);
    set_register(REG_CAPACITY, 32'd1);
    run_random(30, 16, 40, 20);

    // table not installed: every command reports it
    set_register(REG_JAR, 32'd0);
    run_random(30, POOL, 35, 20);

    // back on, room for a single entry
    set_register(REG_JAR, 32'd1);
    set_register(REG_CAPACITY, 32'd2);
    run_random(40, 6, 40, 30);

    // default size, balanced mix
    set_register(REG_CAPACITY, 32'd64);
    run_random(120, 48, 35, 20);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_answers.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
